>>> hdl/etmm_pkg.sv
// Types, constants and rounding helpers shared by the model matrix block.
package etmm_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int XW         = 31;
  localparam logic [XW-1:0] ONE_Q30 = XW'(1 << 30);

  // Odd Taylor coefficients of sin(pi/2 * x), Q30, highest power first
  localparam logic [XW-1:0] POLY_COEF [0:5] = '{
    31'd3864, 31'd172272, 31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713
  };

  typedef struct packed {
    logic signed [31:0]     pos_x;
    logic signed [31:0]     pos_y;
    logic signed [31:0]     pos_z;
    logic [ANGLE_BITS-1:0]  angle_x;
    logic [ANGLE_BITS-1:0]  angle_y;
    logic [ANGLE_BITS-1:0]  angle_z;
    logic signed [31:0]     scale_x;
    logic signed [31:0]     scale_y;
    logic signed [31:0]     scale_z;
  } item_t;

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
    logic signed [31:0] t0;
    logic signed [31:0] t1;
    logic signed [31:0] t2;
  } result_t;

  // One angle split into quadrant and quarter-turn fractions x and 1-x
  typedef struct packed {
    logic [1:0]    quad;
    logic [XW-1:0] x;
    logic [XW-1:0] xc;
  } ang_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
    ang_t               ang_x;
    ang_t               ang_y;
    ang_t               ang_z;
  } entry_t;

  // Fields that ride alongside the sine lanes
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
    logic [1:0]         quad_x;
    logic [1:0]         quad_y;
    logic [1:0]         quad_z;
  } side_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  // Unsigned shift right by 30, rounded to nearest
  function automatic logic [32:0] rnd30_u(input logic [62:0] v);
    logic [62:0] s;
    s = v + 63'(1 << 29);
    return s[62:30];
  endfunction

  // Signed shift right by 30, ties away from zero
  function automatic logic signed [35:0] rnd30_s(input logic signed [65:0] v);
    logic [65:0] mag;
    logic [35:0] m;
    mag = v[65] ? 66'(-v) : 66'(v);
    mag = mag + 66'(1 << 29);
    m   = mag[65:30];
    return v[65] ? -$signed(m) : $signed(m);
  endfunction

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -36'sd2147483648) begin
      return 32'sh80000000;
    end
    return 32'(v);
  endfunction

endpackage

>>> hdl/euler_trs_model_matrix_top.sv
// Top level of the Euler translate-rotate-scale model matrix block.
// Usage:
//   Command channel: drive item and raise start; the command transfers at a
//   rising edge where start is high and busy is low. One command may
//   transfer in every cycle.
//   Result channel: done is high for exactly one cycle with result valid;
//   the result transfers at the edge that ends that cycle. The receiver
//   cannot hold results off, and none is needed: results leave in order.
//   Pipeline: after the queue, a command passes 14 stages in the sine lanes,
//   one for the quadrant fold and 7 in the product, sum, round and scaling
//   stages before done rises.
//   Throughput: one command per cycle; the back end reads the queue every
//   cycle it holds an entry, so busy stays low in normal use.
//   Reset (rst, synchronous, active high) empties the queue and drops every
//   command in flight; no done follows a dropped command.
//   The translation column is passed through; scaled entries saturate to
//   the signed 32-bit range.
module euler_trs_model_matrix_top import etmm_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    done,
  output result_t result
);

  logic   push;
  logic   pop;
  entry_t entry;
  entry_t head;
  qstat_t q_stat;

  assign busy = q_stat.full;
  assign pop  = ~q_stat.empty;

  etmm_front u_front (
    .start (start),
    .busy  (busy),
    .item  (item),
    .push  (push),
    .entry (entry)
  );

  etmm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (entry),
    .pop  (pop),
    .head (head),
    .stat (q_stat)
  );

  etmm_back u_back (
    .clk    (clk),
    .rst    (rst),
    .pop    (pop),
    .head   (head),
    .done   (done),
    .result (result)
  );

`ifndef ASSERT_OFF
  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    !busy) else $error("back end fell behind the queue");
  a_busy_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown(busy)) else $error("busy is unknown");
  a_done_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown(done)) else $error("done is unknown");
`endif

endmodule

>>> hdl/etmm_front.sv
// Front end: accepts commands and splits each angle into quadrant and fractions.
module etmm_front import etmm_pkg::*; (
  input  logic   start,
  input  logic   busy,
  input  item_t  item,
  output logic   push,
  output entry_t entry
);

  function automatic ang_t split(input logic [ANGLE_BITS-1:0] a);
    ang_t r;
    r.quad = a[ANGLE_BITS-1:ANGLE_BITS-2];
    r.x    = XW'(a[ANGLE_BITS-3:0]) << (32 - ANGLE_BITS);
    r.xc   = ONE_Q30 - r.x;
    return r;
  endfunction

  // Take a command whenever the queue has room
  assign push = start & ~busy;

  // Classify the angles and pass lengths through
  always_comb begin
    entry.pos_x   = item.pos_x;
    entry.pos_y   = item.pos_y;
    entry.pos_z   = item.pos_z;
    entry.scale_x = item.scale_x;
    entry.scale_y = item.scale_y;
    entry.scale_z = item.scale_z;
    entry.ang_x   = split(item.angle_x);
    entry.ang_y   = split(item.angle_y);
    entry.ang_z   = split(item.angle_z);
  end

endmodule

>>> hdl/etmm_queue.sv
// Short register queue between front end and arithmetic back end.
module etmm_queue import etmm_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t din,
  input  logic   pop,
  output entry_t head,
  output qstat_t stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t        slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head       = slots[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == CW'(DEPTH));

  // Store incoming entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push && stat.full)) else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(pop && stat.empty)) else $error("queue read while empty");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> count == $past(count) + CW'($past(push)) - CW'($past(pop)))
    else $error("fill count does not follow transfers");
`endif

endmodule

>>> hdl/etmm_qsin.sv
// Quarter-wave sine lane: Horner polynomial over x^2, at most one multiply per stage.
module etmm_qsin import etmm_pkg::*; (
  input  logic          clk,
  input  logic [XW-1:0] x,
  output logic [XW-1:0] s
);

  logic [61:0]   sq;
  logic [XW-1:0] xa;
  logic [XW-1:0] x2p  [0:8];
  logic [XW-1:0] xp   [0:10];
  logic [61:0]   prod [0:4];
  logic [XW-1:0] preg [0:4];
  logic [61:0]   fprod;
  logic [32:0]   x2r;
  logic [32:0]   fr;

  assign x2r = rnd30_u({1'b0, sq});
  assign fr  = rnd30_u({1'b0, fprod});

  // Square x, then round to Q30
  always_ff @(posedge clk) begin
    sq     <= 62'(x) * 62'(x);
    xa     <= x;
    x2p[0] <= x2r[XW-1:0];
    xp[0]  <= xa;
  end

  // Horner steps: multiply, then round and subtract from the next coefficient
  for (genvar i = 0; i < 5; i++) begin : g_step
    logic [XW-1:0] pc;
    logic [32:0]   t;
    if (i == 0) begin : g_first
      assign pc = POLY_COEF[0];
    end else begin : g_rest
      assign pc = preg[i-1];
    end
    assign t = rnd30_u({1'b0, prod[i]});

    always_ff @(posedge clk) begin
      prod[i]     <= 62'(pc) * 62'(x2p[2*i]);
      xp[2*i+1]   <= xp[2*i];
      preg[i]     <= (t > 33'(POLY_COEF[i+1])) ? '0 : XW'(33'(POLY_COEF[i+1]) - t);
      xp[2*i+2]   <= xp[2*i+1];
    end

    if (i < 4) begin : g_fwd
      always_ff @(posedge clk) begin
        x2p[2*i+1] <= x2p[2*i];
        x2p[2*i+2] <= x2p[2*i+1];
      end
    end
  end

  // Final multiply by x, round and clamp to one
  always_ff @(posedge clk) begin
    fprod <= 62'(preg[4]) * 62'(xp[10]);
    s     <= (fr > 33'(ONE_Q30)) ? ONE_Q30 : fr[XW-1:0];
  end

endmodule

>>> hdl/etmm_back.sv
// Back end: sine lanes, rotation products, scaling and saturation pipeline.
module etmm_back import etmm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    pop,
  input  entry_t  head,
  output logic    done,
  output result_t result
);

  localparam int LANE_LAT = 14;
  localparam int LAT      = LANE_LAT + 8;

  logic [LAT-1:0] vld;
  side_t          side_pipe [0:LANE_LAT-1];
  side_t          side_q, side1, side2, side3, side4, side5, side6;

  logic [XW-1:0] sx_x, sc_x, sx_y, sc_y, sx_z, sc_z;

  logic signed [31:0] a_q, b_q, c_q, d_q, e_q, f_q;
  logic signed [31:0] a1, b1, c1, d1, e1, f1;
  logic signed [63:0] bcp, bdp;
  logic signed [31:0] a2, b2, c2, d2, e2, f2, bc2, bd2;
  logic signed [63:0] p_ce, p_bdf, p_de, p_bcf, p_cf, p_bde;
  logic signed [63:0] p_af, p_ae, p_ad, p_df, p_bce, p_ac;
  logic signed [31:0] b3;
  logic signed [64:0] sum4 [0:8];
  logic signed [32:0] r5   [0:8];
  logic signed [64:0] sp6  [0:8];
  logic signed [31:0] scl  [0:8];

  function automatic logic signed [31:0] pick(input logic [1:0] q, input logic [XW-1:0] sx,
                                              input logic [XW-1:0] sc, input logic cos_sel);
    logic signed [31:0] ps, pc;
    ps = $signed(32'(sx));
    pc = $signed(32'(sc));
    case ({q, cos_sel})
      3'b000:  return ps;
      3'b001:  return pc;
      3'b010:  return pc;
      3'b011:  return -ps;
      3'b100:  return -ps;
      3'b101:  return -pc;
      3'b110:  return -pc;
      3'b111:  return ps;
      default: return ps;
    endcase
  endfunction

  // Sine lanes for x and 1-x of each angle
  etmm_qsin u_sx_x (.clk(clk), .x(head.ang_x.x),  .s(sx_x));
  etmm_qsin u_sc_x (.clk(clk), .x(head.ang_x.xc), .s(sc_x));
  etmm_qsin u_sx_y (.clk(clk), .x(head.ang_y.x),  .s(sx_y));
  etmm_qsin u_sc_y (.clk(clk), .x(head.ang_y.xc), .s(sc_y));
  etmm_qsin u_sx_z (.clk(clk), .x(head.ang_z.x),  .s(sx_z));
  etmm_qsin u_sc_z (.clk(clk), .x(head.ang_z.xc), .s(sc_z));

  // Advance the valid marks
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], pop};
    end
  end

  // Delay lengths and quadrants to meet the lane outputs
  always_ff @(posedge clk) begin
    side_pipe[0].pos_x   <= head.pos_x;
    side_pipe[0].pos_y   <= head.pos_y;
    side_pipe[0].pos_z   <= head.pos_z;
    side_pipe[0].scale_x <= head.scale_x;
    side_pipe[0].scale_y <= head.scale_y;
    side_pipe[0].scale_z <= head.scale_z;
    side_pipe[0].quad_x  <= head.ang_x.quad;
    side_pipe[0].quad_y  <= head.ang_y.quad;
    side_pipe[0].quad_z  <= head.ang_z.quad;
    for (int i = 1; i < LANE_LAT; i++) begin
      side_pipe[i] <= side_pipe[i-1];
    end
  end

  // Fold quadrants into signed sine and cosine
  always_ff @(posedge clk) begin
    b_q    <= pick(side_pipe[LANE_LAT-1].quad_x, sx_x, sc_x, 1'b0);
    a_q    <= pick(side_pipe[LANE_LAT-1].quad_x, sx_x, sc_x, 1'b1);
    d_q    <= pick(side_pipe[LANE_LAT-1].quad_y, sx_y, sc_y, 1'b0);
    c_q    <= pick(side_pipe[LANE_LAT-1].quad_y, sx_y, sc_y, 1'b1);
    f_q    <= pick(side_pipe[LANE_LAT-1].quad_z, sx_z, sc_z, 1'b0);
    e_q    <= pick(side_pipe[LANE_LAT-1].quad_z, sx_z, sc_z, 1'b1);
    side_q <= side_pipe[LANE_LAT-1];
  end

  // Form sinX cosY and sinX sinY
  always_ff @(posedge clk) begin
    bcp   <= 64'(b_q) * 64'(c_q);
    bdp   <= 64'(b_q) * 64'(d_q);
    a1    <= a_q;
    b1    <= b_q;
    c1    <= c_q;
    d1    <= d_q;
    e1    <= e_q;
    f1    <= f_q;
    side1 <= side_q;
  end

  // Round the shared products
  always_ff @(posedge clk) begin
    bc2   <= 32'(rnd30_s(66'(bcp)));
    bd2   <= 32'(rnd30_s(66'(bdp)));
    a2    <= a1;
    b2    <= b1;
    c2    <= c1;
    d2    <= d1;
    e2    <= e1;
    f2    <= f1;
    side2 <= side1;
  end

  // Full-precision rotation products
  always_ff @(posedge clk) begin
    p_ce  <= 64'(c2) * 64'(e2);
    p_bdf <= 64'(bd2) * 64'(f2);
    p_de  <= 64'(d2) * 64'(e2);
    p_bcf <= 64'(bc2) * 64'(f2);
    p_cf  <= 64'(c2) * 64'(f2);
    p_bde <= 64'(bd2) * 64'(e2);
    p_af  <= 64'(a2) * 64'(f2);
    p_ae  <= 64'(a2) * 64'(e2);
    p_ad  <= 64'(a2) * 64'(d2);
    p_df  <= 64'(d2) * 64'(f2);
    p_bce <= 64'(bc2) * 64'(e2);
    p_ac  <= 64'(a2) * 64'(c2);
    b3    <= b2;
    side3 <= side2;
  end

  // Sum product pairs per entry where there are two; the others take one product or -sinX
  always_ff @(posedge clk) begin
    sum4[0] <= 65'(p_ce) + 65'(p_bdf);
    sum4[1] <= 65'(p_af);
    sum4[2] <= 65'(p_bcf) - 65'(p_de);
    sum4[3] <= 65'(p_bde) - 65'(p_cf);
    sum4[4] <= 65'(p_ae);
    sum4[5] <= 65'(p_df) + 65'(p_bce);
    sum4[6] <= 65'(p_ad);
    sum4[7] <= -(65'(b3) <<< 30);
    sum4[8] <= 65'(p_ac);
    side4   <= side3;
  end

  // Round entries to Q30
  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      r5[k] <= 33'(rnd30_s(66'(sum4[k])));
    end
    side5 <= side4;
  end

  // Row scales
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      scl[k]   = side5.scale_x;
      scl[k+3] = side5.scale_y;
      scl[k+6] = side5.scale_z;
    end
  end

  // Multiply each entry by its row scale
  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      sp6[k] <= 65'(r5[k]) * 65'(scl[k]);
    end
    side6 <= side5;
  end

  // Round, saturate and hold the result
  always_ff @(posedge clk) begin
    result.m00 <= sat32(rnd30_s(66'(sp6[0])));
    result.m01 <= sat32(rnd30_s(66'(sp6[1])));
    result.m02 <= sat32(rnd30_s(66'(sp6[2])));
    result.m10 <= sat32(rnd30_s(66'(sp6[3])));
    result.m11 <= sat32(rnd30_s(66'(sp6[4])));
    result.m12 <= sat32(rnd30_s(66'(sp6[5])));
    result.m20 <= sat32(rnd30_s(66'(sp6[6])));
    result.m21 <= sat32(rnd30_s(66'(sp6[7])));
    result.m22 <= sat32(rnd30_s(66'(sp6[8])));
    result.t0  <= side6.pos_x;
    result.t1  <= side6.pos_y;
    result.t2  <= side6.pos_z;
  end

  assign done = vld[LAT-1];

endmodule
